/* src/stream_distinct_filter_macros.svh */
// Assertion macros shared by the stream_distinct_filter checker.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef STREAM_DISTINCT_FILTER_MACROS_SVH
`define STREAM_DISTINCT_FILTER_MACROS_SVH

// Same-cycle implication, inactive while reset is held.
`define SDF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stream_distinct_filter: same-cycle check failed");

// Next-cycle implication, inactive while reset is held.
`define SDF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stream_distinct_filter: next-cycle check failed");

`endif

/* src/sdf_pkg.sv */
// Shared constants and types for the stream_distinct_filter block.
// Used by sdf_cell, stream_distinct_filter, sdf_checker and the testbench; depends on nothing.
package sdf_pkg;

    // Number of store entries, one per cell in the chain.
    localparam int CAPACITY = 32;
    // Width of a slot number and of a fill count that can reach CAPACITY.
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths fixed by the interface.
    localparam int VALUE_W  = 32;
    localparam int SLOT_W   = 5;
    localparam int COUNT_W  = 6;

    // Transaction as it travels down the chain of cells.
    typedef struct packed {
        logic [VALUE_W-1:0] value;   // offered value
        logic               done;    // matched or stored in an earlier cell
        logic               is_new;  // stored by one of the cells
        logic [IDX_W-1:0]   slot;    // slot where it was found or stored
        logic [CNT_W-1:0]   count;   // fill count as seen by this transaction
    } t_token;

endpackage

/* src/sdf_cell.sv */
// One cell of the store: holds one entry and passes the transaction token on.
// Depends on sdf_pkg.
module sdf_cell
    import sdf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  logic             i_tok_valid,
    input  t_token           i_tok,
    output logic             o_tok_valid,
    output t_token           o_tok
);

    logic [VALUE_W-1:0] r_value;
    logic               r_tok_valid;
    t_token             r_tok;
    t_token             n_tok;
    logic               occupied;
    logic               hit;
    logic               claim;

    // The entry is live only below the fill count carried by the token.
    assign occupied = CNT_W'(i_index) < i_tok.count;
    assign hit      = occupied && (r_value == i_tok.value);
    // The first free entry takes a value that no earlier cell held.
    assign claim    = !occupied && !i_tok.done;

    // Resolve the token against this entry.
    always_comb begin
        n_tok = i_tok;
        if (!i_tok.done) begin
            if (hit) begin
                n_tok.done = 1'b1;
                n_tok.slot = i_index;
            end else if (claim) begin
                n_tok.done   = 1'b1;
                n_tok.is_new = 1'b1;
                n_tok.slot   = i_index;
                n_tok.count  = i_tok.count + CNT_W'(1);
            end
        end
    end

    // Token valid travels with reset; entry and token payload need none.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (i_tok_valid && claim) begin
            r_value <= i_tok.value;
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

endmodule

/* src/stream_distinct_filter.sv */
// Streaming duplicate filter: each accepted transaction carries one value, which walks a chain
// of CAPACITY cells, one cell per clock, and is compared with the entry held there; a value not
// yet held is written into the first free cell and reported as new with its slot number. One
// transaction is in the chain at a time: the next is accepted only once the result has left the
// cell chain and the result register and has moved into the output register, a move that waits
// while the output register is stalled. The output register lets a finished result wait while
// the next transaction is accepted. begin_set empties the store before its own item.
// Depends on sdf_pkg and sdf_cell.
module stream_distinct_filter
    import sdf_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [VALUE_W-1:0] i_sample_value,
    input  logic                      i_begin_set,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [VALUE_W-1:0] o_echo_value,
    output logic                      o_is_new,
    output logic [SLOT_W-1:0]         o_slot_index,
    output logic [COUNT_W-1:0]        o_distinct_count,
    output logic                      o_overflow
);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               is_new;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } t_result;

    logic            chain_valid [0:CAPACITY];
    t_token          chain_tok   [0:CAPACITY];
    t_token          launch_tok;
    logic            in_accept;
    logic            out_free;
    logic            r_busy;
    logic            n_busy;
    logic [CNT_W-1:0] r_fill;
    logic            r_pend_valid;
    t_result         r_pend;
    t_result         n_pend;
    logic            r_out_valid;
    t_result         r_out;
    t_token          tail;

    assign in_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = !r_busy;
    assign out_free   = !r_out_valid || i_out_ready;

    // Launch token: begin_set restarts the union with an empty store.
    always_comb begin
        launch_tok.value  = $unsigned(i_sample_value);
        launch_tok.done   = 1'b0;
        launch_tok.is_new = 1'b0;
        launch_tok.slot   = '0;
        launch_tok.count  = i_begin_set ? '0 : r_fill;
    end

    assign chain_valid[0] = in_accept;
    assign chain_tok[0]   = launch_tok;

    // The row of cells, each holding one store entry.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        sdf_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_index     (IDX_W'(g)),
            .i_tok_valid (chain_valid[g]),
            .i_tok       (chain_tok[g]),
            .o_tok_valid (chain_valid[g+1]),
            .o_tok       (chain_tok[g+1])
        );
    end

    assign tail = chain_tok[CAPACITY];

    // Turn the token leaving the last cell into a result; unresolved means the store is full.
    always_comb begin
        n_pend.value    = tail.value;
        n_pend.is_new   = tail.is_new;
        n_pend.slot     = tail.done ? SLOT_W'(tail.slot) : '0;
        n_pend.count    = COUNT_W'(tail.count);
        n_pend.overflow = !tail.done;
    end

    // The block stays busy until its result has reached the output register.
    always_comb begin
        n_busy = r_busy;
        if (in_accept) begin
            n_busy = 1'b1;
        end else if (r_pend_valid && out_free) begin
            n_busy = 1'b0;
        end
    end

    // Control: busy flag, fill count and the valid bits of result and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_fill       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (chain_valid[CAPACITY]) begin
                r_fill       <= tail.count;
                r_pend_valid <= 1'b1;
            end else if (r_pend_valid && out_free) begin
                r_pend_valid <= 1'b0;
            end
            if (r_pend_valid && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        if (chain_valid[CAPACITY]) begin
            r_pend <= n_pend;
        end
        if (r_pend_valid && out_free) begin
            r_out <= r_pend;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_echo_value     = $signed(r_out.value);
    assign o_is_new         = r_out.is_new;
    assign o_slot_index     = r_out.slot;
    assign o_distinct_count = r_out.count;
    assign o_overflow       = r_out.overflow;

endmodule

/* src/sdf_checker.sv */
// Port-level checks for stream_distinct_filter, attached by the bind at the end of this file.
// Depends on sdf_pkg and stream_distinct_filter_macros.svh.
`include "stream_distinct_filter_macros.svh"

module sdf_checker
    import sdf_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic signed [VALUE_W-1:0] o_echo_value,
    input logic                      o_is_new,
    input logic [SLOT_W-1:0]         o_slot_index,
    input logic [COUNT_W-1:0]        o_distinct_count,
    input logic                      o_overflow
);

    // Only one transaction is in flight, so an accepted input closes the input channel.
    `SDF_ASSERT_NEXT(a_in_busy, i_in_valid && o_in_ready, !o_in_ready)

    // A dropped value is never also reported as stored.
    `SDF_ASSERT_NOW(a_ovf_not_new, o_out_valid && o_overflow, !o_is_new)

    // Overflow only happens with a full store and reports slot zero.
    `SDF_ASSERT_NOW(a_ovf_full, o_out_valid && o_overflow,
        (o_distinct_count == COUNT_W'(CAPACITY)) && (o_slot_index == '0))

    // A newly stored value lands in the last occupied slot.
    `SDF_ASSERT_NOW(a_new_slot, o_out_valid && o_is_new,
        (o_distinct_count != '0) && (o_slot_index == SLOT_W'(o_distinct_count - 1'b1)))

    // A stalled result transaction holds its value.
    `SDF_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_echo_value))

endmodule

bind stream_distinct_filter sdf_checker u_sdf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_echo_value     (o_echo_value),
    .o_is_new         (o_is_new),
    .o_slot_index     (o_slot_index),
    .o_distinct_count (o_distinct_count),
    .o_overflow       (o_overflow)
);

/* dv/stream_distinct_filter_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for stream_distinct_filter: a tracker class predicts each result,
// plain tasks drive value streams through the valid/ready channels. Depends on sdf_pkg and the RTL.
module stream_distinct_filter_tb;
    import sdf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500_000;
    localparam int unsigned RANDOM_ITEMS = 430;
    localparam int unsigned SETTLE_CYCLES = 2 * (CAPACITY + 3);

    // One expected result of the filter.
    typedef struct {
        logic signed [VALUE_W-1:0] echo_value;
        logic                      is_new;
        logic [SLOT_W-1:0]         slot_index;
        logic [COUNT_W-1:0]        distinct_count;
        logic                      overflow;
    } t_sdf_verdict;

    // Tracks the stored set as the block should hold it and checks each result in order.
    class distinct_tracker;
        logic signed [VALUE_W-1:0] held [CAPACITY];
        int unsigned               fill;
        t_sdf_verdict              awaited[$];
        int unsigned               mismatches;
        int unsigned               checked;
        int unsigned               dropped;

        function new();
            fill = 0;
            mismatches = 0;
            checked = 0;
            dropped = 0;
        endfunction

        // Prints one line per failure and counts every one.
        task report_mismatch(input string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        // Works out the result of one accepted transaction and queues it.
        function void note_offer(input logic signed [VALUE_W-1:0] value, input logic restart);
            t_sdf_verdict v;
            int unsigned  i;
            bit           found;
            if (restart) begin
                fill = 0;
            end
            found = 1'b0;
            v.echo_value = value;
            v.is_new = 1'b0;
            v.overflow = 1'b0;
            v.slot_index = '0;
            for (i = 0; i < fill; i++) begin
                if (!found && held[i] == value) begin
                    found = 1'b1;
                    v.slot_index = i[SLOT_W-1:0];
                end
            end
            if (!found) begin
                if (fill < CAPACITY) begin
                    held[fill] = value;
                    v.slot_index = fill[SLOT_W-1:0];
                    v.is_new = 1'b1;
                    fill++;
                end else begin
                    v.overflow = 1'b1;
                end
            end
            v.distinct_count = fill[COUNT_W-1:0];
            awaited.push_back(v);
        endfunction

        // Compares one accepted result with the oldest expectation.
        task check_verdict(input logic signed [VALUE_W-1:0] value, input logic is_new,
                           input logic [SLOT_W-1:0] slot, input logic [COUNT_W-1:0] count,
                           input logic ovf);
            t_sdf_verdict exp_v;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("unexpected result, value %0d", value));
            end else begin
                exp_v = awaited.pop_front();
                checked++;
                if (exp_v.overflow) begin
                    dropped++;
                end
                if (value !== exp_v.echo_value || is_new !== exp_v.is_new
                    || slot !== exp_v.slot_index || count !== exp_v.distinct_count
                    || ovf !== exp_v.overflow) begin
                    report_mismatch($sformatf(
                        "got val %0d new %b slot %0d cnt %0d ovf %b, want %0d %b %0d %0d %b",
                        value, is_new, slot, count, ovf, exp_v.echo_value, exp_v.is_new,
                        exp_v.slot_index, exp_v.distinct_count, exp_v.overflow));
                end
            end
        endtask
    endclass

    logic                      i_clk;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic signed [VALUE_W-1:0] i_sample_value = '0;
    logic                      i_begin_set = 1'b0;
    logic                      i_out_ready = 1'b1;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic signed [VALUE_W-1:0] o_echo_value;
    logic                      o_is_new;
    logic [SLOT_W-1:0]         o_slot_index;
    logic [COUNT_W-1:0]        o_distinct_count;
    logic                      o_overflow;

    distinct_tracker tracker = new();
    int unsigned     send_idle_pct = 9;
    int unsigned     recv_stall_pct = 47;
    int unsigned     cycle_count = 0;
    int unsigned     offers_accepted = 0;
    int unsigned     sets_started = 0;

    stream_distinct_filter u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample_value   (i_sample_value),
        .i_begin_set      (i_begin_set),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_echo_value     (o_echo_value),
        .o_is_new         (o_is_new),
        .o_slot_index     (o_slot_index),
        .o_distinct_count (o_distinct_count),
        .o_overflow       (o_overflow)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("stream_distinct_filter regression: fail");
            $finish;
        end
    end

    // Receiver back-pressure, changed at the falling edge.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every result transaction is checked at the rising edge it is accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_verdict(o_echo_value, o_is_new, o_slot_index, o_distinct_count,
                                  o_overflow);
        end
    end

    // A random value that hits the extremes now and then.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(15))
            0: pick_value = 32'sh7fff_ffff;
            1: pick_value = 32'sh8000_0000;
            2: pick_value = '0;
            3: pick_value = -32'sd1;
            default: pick_value = $urandom;
        endcase
    endfunction

    // Offers one transaction, idling first at random; called and returns at a falling edge.
    task automatic offer(input logic signed [VALUE_W-1:0] value, input logic restart);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_value <= value;
        i_begin_set <= restart;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_offer(value, restart);
        offers_accepted++;
        if (restart) begin
            sets_started++;
        end
        @(negedge i_clk);
    endtask

    // Holds the sender off until every expected result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (tracker.awaited.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // A well-formed union drawn from a small pool, so duplicates are frequent.
    task automatic run_pool_set();
        logic signed [VALUE_W-1:0] pool[$];
        int unsigned               pool_size;
        int unsigned               length;
        int unsigned               k;
        pool_size = $urandom_range(12, 1);
        length = $urandom_range(20, 1);
        for (k = 0; k < pool_size; k++) begin
            pool.push_back(pick_value());
        end
        for (k = 0; k < length; k++) begin
            offer(pool[$urandom_range(pool_size - 1)], (k == 0) || ($urandom_range(32) == 0));
        end
    endtask

    // A union that fills the store, then offers both fresh and stored values.
    task automatic run_filling_set(output int unsigned length);
        logic signed [VALUE_W-1:0] offered[$];
        logic signed [VALUE_W-1:0] value;
        int unsigned               k;
        length = $urandom_range(CAPACITY + 12, CAPACITY + 1);
        for (k = 0; k < length; k++) begin
            if (k >= CAPACITY && $urandom_range(3) == 0) begin
                value = offered[$urandom_range(offered.size() - 1)];
            end else begin
                value = $urandom;
            end
            offered.push_back(value);
            offer(value, k == 0);
        end
    endtask

    // Main sequence: reset, directed cases, then random unions over three idling phases.
    initial begin
        int unsigned random_offers;
        int unsigned n;
        int unsigned phase;
        int unsigned next_phase;
        int unsigned choice;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Extremes and repeats in the union left by reset.
        offer('0, 1'b0);
        offer(32'sh7fff_ffff, 1'b0);
        offer(32'sh8000_0000, 1'b0);
        offer(-32'sd1, 1'b0);
        offer('0, 1'b0);
        offer(32'sh8000_0000, 1'b0);
        offer(32'sd1, 1'b0);
        offer(32'sh5555_5555, 1'b0);
        offer(32'shaaaa_aaaa, 1'b0);
        offer(-32'sd1, 1'b0);
        // A new union starts with a value that was already stored.
        offer(32'sh7fff_ffff, 1'b1);
        offer(32'sh7fff_ffff, 1'b0);
        offer('0, 1'b0);
        offer(32'sh7fff_ffff, 1'b1);
        offer('0, 1'b0);
        offer(32'sh8000_0000, 1'b1);
        offer(32'sh8000_0000, 1'b1);
        offer(32'sh7fff_fffe, 1'b0);
        offer(32'sh8000_0001, 1'b0);
        offer(32'sh8000_0001, 1'b0);
        drain_results();

        // The first random union offers more values than the store holds.
        random_offers = 0;
        phase = 0;
        run_filling_set(n);
        random_offers += n;
        while (random_offers < RANDOM_ITEMS) begin
            next_phase = (random_offers < RANDOM_ITEMS / 3) ? 0 :
                         (random_offers < 2 * RANDOM_ITEMS / 3) ? 1 : 2;
            if (next_phase != phase) begin
                drain_results();
                phase = next_phase;
                send_idle_pct = (phase == 1) ? 47 : 0;
                recv_stall_pct = (phase == 1) ? 9 : 0;
            end
            choice = $urandom_range(19);
            if (choice < 2) begin
                run_filling_set(n);
            end else if (choice < 17) begin
                n = tracker.awaited.size();
                run_pool_set();
                n = 0;
            end else begin
                // Noise: loose values with the odd restart, continuing the current union.
                n = $urandom_range(6, 1);
                repeat (n) offer(pick_value(), $urandom_range(9) == 0);
            end
            random_offers = offers_accepted - 20;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (tracker.awaited.size() != 0) begin
            tracker.report_mismatch($sformatf("%0d results never arrived",
                                              tracker.awaited.size()));
        end

        $display("Offered %0d values across %0d started unions; %0d results checked.",
                 offers_accepted, sets_started, tracker.checked);
        $display("%0d values were dropped on a full store; %0d mismatches.",
                 tracker.dropped, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("stream_distinct_filter regression: pass");
        end else begin
            $display("stream_distinct_filter regression: fail");
        end
        $finish;
    end

endmodule

/* stream_distinct_filter.f */
+incdir+src
src/sdf_pkg.sv
src/sdf_cell.sv
src/stream_distinct_filter.sv
src/sdf_checker.sv
dv/stream_distinct_filter_tb.sv
